// ===== hdl/sorted_list_insert_remove_find_core_macros.svh =====
// ----------------------------------------------------------------------------
// sorted list core assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_REMOVE_FIND_CORE_MACROS_SVH
`define SORTED_LIST_INSERT_REMOVE_FIND_CORE_MACROS_SVH

// same-cycle implication
`define SL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/sl_pkg.sv =====
// ----------------------------------------------------------------------------
// sl_pkg
// shared types and constants of the sorted list core
// ----------------------------------------------------------------------------
`default_nettype none

package sl_pkg;

   localparam int unsigned SL_CAPACITY  = 16;
   localparam int unsigned VALUE_WIDTH  = 32;
   localparam int unsigned FIELD_WIDTH  = 5;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2
   } sl_op_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CMP  = 3'b010,
      ST_UPD  = 3'b100
   } sl_state_type;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic compare;
      logic insert;
      logic remove;
   } sl_cmd_type;

endpackage

`default_nettype wire

// ===== hdl/sl_cell.sv =====
// ----------------------------------------------------------------------------
// sl_cell
// one slot of the sorted row: holds an entry, compares it against the
// broadcast value and shifts with its neighbors
// ----------------------------------------------------------------------------
`default_nettype none

module sl_cell import sl_pkg::*; #(
   parameter int unsigned CAPACITY = SL_CAPACITY,
   parameter int unsigned INDEX    = 0,
   localparam int unsigned CW      = $clog2(CAPACITY + 1)
) (
   input  wire logic                          clock,
   input  wire sl_cmd_type                    cmd,
   input  wire logic signed [VALUE_WIDTH-1:0] value,
   input  wire logic [CW-1:0]                 count,
   input  wire logic signed [VALUE_WIDTH-1:0] left_entry,
   input  wire logic                          left_gt,
   input  wire logic signed [VALUE_WIDTH-1:0] right_entry,
   output logic signed [VALUE_WIDTH-1:0]      entry,
   output logic                               gt,
   output logic                               eq
);

   logic signed [VALUE_WIDTH-1:0] entry_ff, entry_in;
   logic                          gt_ff, ge_ff, eq_ff;
   logic                          valid;

   assign valid = count > CW'(INDEX);

   // free slots count as greater so an insert lands at the tail
   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         gt_ff <= !valid || (entry_ff > value);
         ge_ff <= valid && (entry_ff >= value);
         eq_ff <= valid && (entry_ff == value);
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (left_gt) begin
            entry_in = left_entry;
         end else if (gt_ff) begin
            entry_in = value;
         end
      end else if (cmd.remove) begin
         if (ge_ff) begin
            entry_in = right_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign gt    = gt_ff;
   assign eq    = eq_ff;

endmodule

`default_nettype wire

// ===== hdl/sl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sl_ctrl
// sequencer: captures an item, runs compare then update over the cell row,
// and holds the result register
// ----------------------------------------------------------------------------
`default_nettype none

module sl_ctrl import sl_pkg::*; #(
   parameter int unsigned CAPACITY = SL_CAPACITY,
   localparam int unsigned CW      = $clog2(CAPACITY + 1),
   localparam int unsigned IW      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_success,
   output logic signed [FIELD_WIDTH-1:0]      rsp_position,
   output logic [FIELD_WIDTH-1:0]             rsp_count,
   output sl_cmd_type                         cmd,
   output logic signed [VALUE_WIDTH-1:0]      value,
   output logic [CW-1:0]                      count,
   input  wire logic [CAPACITY-1:0]           eq_vec
);

   sl_state_type                  state_ff, state_in;
   logic [1:0]                    op_ff;
   logic signed [VALUE_WIDTH-1:0] value_ff;
   logic [CW-1:0]                 count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_success_ff, rsp_success_in;
   logic [FIELD_WIDTH-1:0]        rsp_position_ff, rsp_position_in;
   logic [FIELD_WIDTH-1:0]        rsp_count_ff;
   logic [CAPACITY-1:0]           first_eq;
   logic [IW-1:0]                 pos_idx;
   logic                          hit, full, slot_free, commit;

   assign req_ready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_UPD) && slot_free;
   assign hit       = |eq_vec;
   assign full      = (count_ff == CW'(CAPACITY));

   // equal entries sit together, so the first one has no equal left neighbor
   assign first_eq = eq_vec & ~(eq_vec << 1);

   always_comb begin
      pos_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first_eq[i]) begin
            pos_idx = pos_idx | IW'(i);
         end
      end
   end

   assign cmd.compare = (state_ff == ST_CMP);
   assign cmd.insert  = commit && (op_ff == OP_INSERT) && !full;
   assign cmd.remove  = commit && (op_ff == OP_REMOVE) && hit;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.remove) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_success_in  = cmd.insert || cmd.remove || ((op_ff == OP_FIND) && hit);
      rsp_position_in = '1;
      if ((op_ff == OP_FIND) && hit) begin
         rsp_position_in = FIELD_WIDTH'(pos_idx);
      end
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff    <= req_opcode;
         value_ff <= req_value;
      end
      if (commit) begin
         rsp_success_ff  <= rsp_success_in;
         rsp_position_ff <= rsp_position_in;
         rsp_count_ff    <= FIELD_WIDTH'(count_in);
      end
   end

   assign value        = value_ff;
   assign count        = count_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_success  = rsp_success_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

`default_nettype wire

// ===== hdl/sorted_list_insert_remove_find_core.sv =====
// an accepted item runs a compare pass over the cell row, then an update pass into the result register
// a new item is accepted only once the update pass of the previous item has completed
// a waiting result does not block the next accept; the update stalls until the result is taken
// reset (synchronous, active high) empties the list and drops any pending result
// entry contents are not cleared by reset; only slots below the count are ever used
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_find_core
// bounded ascending list of signed values built as a row of shifting cells
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_remove_find_core import sl_pkg::*; #(
   parameter int unsigned CAPACITY = SL_CAPACITY
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_success,
   output logic signed [FIELD_WIDTH-1:0]      rsp_position,
   output logic [FIELD_WIDTH-1:0]             rsp_count
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);

   sl_cmd_type                    cmd;
   logic signed [VALUE_WIDTH-1:0] value;
   logic [CW-1:0]                 count;
   logic signed [VALUE_WIDTH-1:0] entry_vec [CAPACITY];
   logic [CAPACITY-1:0]           gt_vec;
   logic [CAPACITY-1:0]           eq_vec;

   sl_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_success  (rsp_success),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count),
      .cmd          (cmd),
      .value        (value),
      .count        (count),
      .eq_vec       (eq_vec)
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_WIDTH-1:0] left_entry;
      logic                          left_gt;
      logic signed [VALUE_WIDTH-1:0] right_entry;

      // row ends: nothing to the left, last slot keeps itself on removal
      if (i == 0) begin : g_first
         assign left_entry = '0;
         assign left_gt    = 1'b0;
      end else begin : g_mid
         assign left_entry = entry_vec[i-1];
         assign left_gt    = gt_vec[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = entry_vec[i];
      end else begin : g_inner
         assign right_entry = entry_vec[i+1];
      end

      sl_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .value       (value),
         .count       (count),
         .left_entry  (left_entry),
         .left_gt     (left_gt),
         .right_entry (right_entry),
         .entry       (entry_vec[i]),
         .gt          (gt_vec[i]),
         .eq          (eq_vec[i])
      );
   end

endmodule

`default_nettype wire

// ===== hdl/sl_checker.sv =====
// ----------------------------------------------------------------------------
// sl_checker
// port-level checks of the sorted list core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_list_insert_remove_find_core_macros.svh"

module sl_checker import sl_pkg::*; (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_success,
   input wire logic signed [FIELD_WIDTH-1:0] rsp_position,
   input wire logic [FIELD_WIDTH-1:0]        rsp_count
);

   logic find_hit_shown;

   assign find_hit_shown = rsp_valid && (rsp_position != '1);

   // a stalled result keeps its payload
   `SL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_success) && $stable(rsp_position) && $stable(rsp_count), "stalled result changed")

   // a real position only comes with a find hit
   `SL_ASSERT_NOW(a_pos_success, clock, reset, find_hit_shown, rsp_success, "position without success")

   // one item in flight: no accept right after an accept
   `SL_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "back-to-back accept")

endmodule

bind sorted_list_insert_remove_find_core sl_checker u_sl_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_success  (rsp_success),
   .rsp_position (rsp_position),
   .rsp_count    (rsp_count)
);

`default_nettype wire

// ===== sim/sorted_list_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted list checker
// watches both channels of the sorted list core, keeps its own copy of the
// list and compares every result against the oldest prediction
// ----------------------------------------------------------------------------

module sorted_list_checker import sl_pkg::*; (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_ready,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic signed [VALUE_WIDTH-1:0] req_value,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic                          rsp_success,
   input  wire logic signed [FIELD_WIDTH-1:0] rsp_position,
   input  wire logic [FIELD_WIDTH-1:0]        rsp_count,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 results_checked,
   output int                                 peak_count,
   output int                                 full_rejects
);

   localparam logic signed [FIELD_WIDTH-1:0] NOT_FOUND = '1;

   typedef struct packed {
      logic                          success;
      logic signed [FIELD_WIDTH-1:0] position;
      logic [FIELD_WIDTH-1:0]        count;
   } list_result_type;

   logic signed [VALUE_WIDTH-1:0] list_vals [SL_CAPACITY];
   int                            list_len = 0;
   list_result_type               expected_q [$];

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // applies one operation to the local list and returns what the core must answer
   function automatic list_result_type apply_list_op(input logic [1:0] op,
                                                     input logic signed [VALUE_WIDTH-1:0] value);
      list_result_type r;
      int              hit;
      int              slot;
      r.success  = 1'b0;
      r.position = NOT_FOUND;
      hit = -1;
      for (int i = list_len - 1; i >= 0; i--)
         if (list_vals[i] == value) hit = i;
      case (op)
         OP_INSERT: begin
            if (list_len < SL_CAPACITY) begin
               // lands before the first strictly greater entry
               slot = list_len;
               for (int i = list_len - 1; i >= 0; i--)
                  if (list_vals[i] > value) slot = i;
               for (int i = list_len; i > slot; i--)
                  list_vals[i] = list_vals[i-1];
               list_vals[slot] = value;
               list_len++;
               r.success = 1'b1;
            end else begin
               full_rejects++;
            end
         end
         OP_REMOVE: begin
            if (hit >= 0) begin
               for (int i = hit; i + 1 < list_len; i++)
                  list_vals[i] = list_vals[i+1];
               list_len--;
               r.success = 1'b1;
            end
         end
         OP_FIND: begin
            if (hit >= 0) begin
               r.success  = 1'b1;
               r.position = hit[FIELD_WIDTH-1:0];
            end
         end
         default: ;
      endcase
      r.count = list_len[FIELD_WIDTH-1:0];
      if (list_len > peak_count) peak_count = list_len;
      return r;
   endfunction

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         list_len = 0;
         expected_q.delete();
      end else begin
         // check the result first so a fresh item never pairs with it
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch($sformatf("result with nothing outstanding (success %b count %0d)",
                                         rsp_success, rsp_count));
            end else begin
               want = expected_q.pop_front();
               results_checked++;
               if (rsp_success !== want.success)
                  report_mismatch($sformatf("success got %b, expected %b",
                                            rsp_success, want.success));
               if (rsp_position !== want.position)
                  report_mismatch($sformatf("position got %0d, expected %0d",
                                            rsp_position, want.position));
               if (rsp_count !== want.count)
                  report_mismatch($sformatf("count got %0d, expected %0d",
                                            rsp_count, want.count));
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(apply_list_op(req_opcode, req_value));
      end
      pending <= expected_q.size();
   end

endmodule

// ===== sim/tb_sorted_list_insert_remove_find_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_remove_find_core
// drives insert, remove, find and unused-opcode items into the sorted list
// core with random gaps and back-pressure; the checker predicts and compares
// ----------------------------------------------------------------------------

module tb_sorted_list_insert_remove_find_core;
   import sl_pkg::*;

   localparam logic [1:0]                    OP_UNUSED    = 2'd3;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN    = 32'sh8000_0000;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX    = 32'sh7fff_ffff;
   localparam int                            RANDOM_ITEMS = 880;
   localparam int                            PHASE_LEN    = 60;
   localparam int                            MIX_FILL     = 0;
   localparam int                            MIX_DRAIN    = 1;
   localparam int                            MIX_EVEN     = 2;
   localparam int                            STALL_LIMIT  = 1000;
   localparam int                            DRAIN_CYCLES = 12;

   logic                          clock        = 1'b0;
   logic                          reset        = 1'b1;
   logic                          req_valid    = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_opcode   = OP_INSERT;
   logic signed [VALUE_WIDTH-1:0] req_value    = '0;
   logic                          rsp_valid;
   logic                          rsp_ready    = 1'b0;
   logic                          rsp_success;
   logic signed [FIELD_WIDTH-1:0] rsp_position;
   logic [FIELD_WIDTH-1:0]        rsp_count;

   logic                          calm         = 1'b0;
   int                            idle_cycles  = 0;
   int                            items_by_op [4] = '{default: 0};
   logic signed [VALUE_WIDTH-1:0] wide_seen [$];

   int fail_count;
   int pending;
   int results_checked;
   int peak_count;
   int full_rejects;

   sorted_list_insert_remove_find_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_success  (rsp_success),
      .rsp_position (rsp_position),
      .rsp_count    (rsp_count)
   );

   sorted_list_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_success     (rsp_success),
      .rsp_position    (rsp_position),
      .rsp_count       (rsp_count),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_checked (results_checked),
      .peak_count      (peak_count),
      .full_rejects    (full_rejects)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 9);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // holds valid until the core takes the item; valid stays high for the next one unless a random gap drops it
   task automatic send_item(input logic [1:0] op, input logic signed [VALUE_WIDTH-1:0] v);
      if (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 30);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_by_op[op]++;
   endtask

   // the checker's count is registered, so look only after the next edge
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [1:0] choose_op(input int mix);
      int r;
      r = $urandom_range(99);
      case (mix)
         MIX_FILL:  return r < 70 ? OP_INSERT : r < 80 ? OP_REMOVE : r < 96 ? OP_FIND : OP_UNUSED;
         MIX_DRAIN: return r < 15 ? OP_INSERT : r < 75 ? OP_REMOVE : r < 96 ? OP_FIND : OP_UNUSED;
         default:   return r < 40 ? OP_INSERT : r < 70 ? OP_REMOVE : r < 97 ? OP_FIND : OP_UNUSED;
      endcase
   endfunction

   // small pool keeps hits and duplicates frequent; wide values are tracked so
   // they can be removed again and do not clog the list
   function automatic logic signed [VALUE_WIDTH-1:0] pick_value(input logic [1:0] op);
      int                            r;
      logic signed [VALUE_WIDTH-1:0] v;
      r = $urandom_range(99);
      if (r < 4) begin
         v = $urandom;
         if (op == OP_INSERT) begin
            wide_seen.push_back(v);
            if (wide_seen.size() > 8) void'(wide_seen.pop_front());
         end
      end else if (op != OP_INSERT && r < 30 && wide_seen.size() != 0) begin
         v = wide_seen[$urandom_range(wide_seen.size() - 1)];
      end else if (r < 38) begin
         v = $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
      end else begin
         v = int'($urandom_range(10)) - 5;
      end
      return v;
   endfunction

   task automatic run_directed();
      send_item(OP_REMOVE, 5);          // remove on empty list
      send_item(OP_FIND, 5);            // find on empty list
      send_item(OP_UNUSED, -1);
      send_item(OP_INSERT, VALUE_MAX);
      send_item(OP_INSERT, VALUE_MIN);
      send_item(OP_INSERT, 0);
      send_item(OP_INSERT, 0);          // equal value goes after the first
      send_item(OP_INSERT, -1);
      send_item(OP_FIND, 0);
      send_item(OP_FIND, VALUE_MIN);
      send_item(OP_FIND, VALUE_MAX);
      send_item(OP_FIND, 1);            // absent
      send_item(OP_REMOVE, 1);          // absent
      send_item(OP_REMOVE, 0);
      send_item(OP_REMOVE, VALUE_MAX);  // last slot
      send_item(OP_REMOVE, VALUE_MIN);  // first slot
      send_item(OP_UNUSED, 0);
   endtask

   initial begin
      int mix;
      mix = MIX_FILL;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      hold_until_drained();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_LEN == 0) mix = (n == 0) ? MIX_FILL : $urandom_range(MIX_EVEN);
         calm = (n >= 300 && n < 450);
         if (n == 600) hold_until_drained();
         begin
            logic [1:0] op;
            op = choose_op(mix);
            send_item(op, pick_value(op));
         end
      end

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("items: %0d insert, %0d remove, %0d find, %0d unused opcode; %0d results checked",
               items_by_op[OP_INSERT], items_by_op[OP_REMOVE], items_by_op[OP_FIND],
               items_by_op[OP_UNUSED], results_checked);
      $display("list reached %0d of %0d entries, %0d inserts refused on a full list",
               peak_count, SL_CAPACITY, full_rejects);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
